[rtl/qrm_pkg.sv]
// ============================================================================
// qrm_pkg: shared types and constants for the quaternion to rotation matrix
// Widths, lane layout and the restoring division step.
// ============================================================================
package qrm_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int LANES     = 9;
    localparam int Q_BITS    = 15;               // quotient bits, 0..16384
    localparam int R_W       = 34;               // remainder / divisor width
    localparam int N_W       = 33;               // squared norm width
    localparam int S_W       = 35;               // signed sum width
    localparam int NM_W      = N_W + Q_BITS;     // dividend width
    localparam int DIV_STEPS = 3;                // quotient bits per stage
    localparam int DIV_STAGES = Q_BITS / DIV_STEPS;
    localparam int ONE_Q14   = 16384;

    typedef struct packed {
        logic              neg;
        logic [R_W-1:0]    r;
        logic [Q_BITS-1:0] low;
        logic [Q_BITS-1:0] q;
    } t_lane;

    typedef struct packed {
        logic [R_W-1:0]         d;
        logic                   zero;
        t_lane [LANES-1:0]      lane;
    } t_div;

    typedef logic signed [OUT_W-1:0] t_elem;

    // one restoring division step: shift in a dividend bit, subtract if it fits
    function automatic t_lane div_step(input t_lane l, input logic [R_W-1:0] d);
        t_lane       o;
        logic [R_W:0] t;
        o = l;
        t = {l.r, l.low[Q_BITS-1]};
        if (t >= {1'b0, d}) begin
            o.r = R_W'(t - {1'b0, d});
            o.q = {l.q[Q_BITS-2:0], 1'b1};
        end else begin
            o.r = t[R_W-1:0];
            o.q = {l.q[Q_BITS-2:0], 1'b0};
        end
        o.low = {l.low[Q_BITS-2:0], 1'b0};
        return o;
    endfunction

endpackage

[rtl/qrm_if.sv]
// ============================================================================
// qrm_quat_if / qrm_mat_if: valid/ready channels
// Input quaternion channel and output matrix channel.
// ============================================================================
interface qrm_quat_if;
    logic                              valid;
    logic                              ready;
    logic signed [qrm_pkg::IN_W-1:0]   quat_x;
    logic signed [qrm_pkg::IN_W-1:0]   quat_y;
    logic signed [qrm_pkg::IN_W-1:0]   quat_z;
    logic signed [qrm_pkg::IN_W-1:0]   quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qrm_mat_if;
    logic           valid;
    logic           ready;
    qrm_pkg::t_elem elem_0;
    qrm_pkg::t_elem elem_1;
    qrm_pkg::t_elem elem_2;
    qrm_pkg::t_elem elem_4;
    qrm_pkg::t_elem elem_5;
    qrm_pkg::t_elem elem_6;
    qrm_pkg::t_elem elem_8;
    qrm_pkg::t_elem elem_9;
    qrm_pkg::t_elem elem_10;
    logic           zero_norm;

    modport source (output valid, elem_0, elem_1, elem_2, elem_4, elem_5, elem_6,
                    elem_8, elem_9, elem_10, zero_norm, input ready);
    modport sink   (input valid, elem_0, elem_1, elem_2, elem_4, elem_5, elem_6,
                    elem_8, elem_9, elem_10, zero_norm, output ready);
endinterface

[rtl/qrm_front.sv]
// ============================================================================
// qrm_front: products, sums and dividend setup
// Four stages: input register, ten products, norm and numerators, lane setup.
// ============================================================================
module qrm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [qrm_pkg::IN_W-1:0] i_x,
    input  logic signed [qrm_pkg::IN_W-1:0] i_y,
    input  logic signed [qrm_pkg::IN_W-1:0] i_z,
    input  logic signed [qrm_pkg::IN_W-1:0] i_w,
    output logic                            o_valid,
    input  logic                            i_ready,
    output qrm_pkg::t_div                   o_div
);
    localparam int P_W = 2 * qrm_pkg::IN_W;

    // product order: xx yy zz ww xy xz yz xw yw zw
    logic                                 r_v1, r_v2, r_v3, r_v4;
    logic signed [qrm_pkg::IN_W-1:0]      r_x, r_y, r_z, r_w;
    logic signed [P_W-1:0]                r_p [10];
    logic signed [P_W-1:0]                n_p [10];
    logic [qrm_pkg::N_W-1:0]              r_n;
    logic signed [qrm_pkg::S_W-1:0]       r_num [qrm_pkg::LANES];
    logic signed [qrm_pkg::S_W-1:0]       n_num [qrm_pkg::LANES];
    logic signed [qrm_pkg::S_W-1:0]       n_sum;
    qrm_pkg::t_div                        r_div, n_div;
    logic                                 en1, en2, en3, en4;

    function automatic logic signed [qrm_pkg::S_W-1:0] ext(input logic signed [P_W-1:0] p);
        return {{(qrm_pkg::S_W - P_W){p[P_W-1]}}, p};
    endfunction

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v4;
    assign o_div   = r_div;

    always_comb begin
        n_p[0] = r_x * r_x;
        n_p[1] = r_y * r_y;
        n_p[2] = r_z * r_z;
        n_p[3] = r_w * r_w;
        n_p[4] = r_x * r_y;
        n_p[5] = r_x * r_z;
        n_p[6] = r_y * r_z;
        n_p[7] = r_x * r_w;
        n_p[8] = r_y * r_w;
        n_p[9] = r_z * r_w;
    end

    always_comb begin
        n_sum    = ext(r_p[0]) + ext(r_p[1]) + ext(r_p[2]) + ext(r_p[3]);
        n_num[0] = ext(r_p[0]) + ext(r_p[3]) - ext(r_p[1]) - ext(r_p[2]);
        n_num[1] = (ext(r_p[4]) + ext(r_p[9])) <<< 1;
        n_num[2] = (ext(r_p[5]) - ext(r_p[8])) <<< 1;
        n_num[3] = (ext(r_p[4]) - ext(r_p[9])) <<< 1;
        n_num[4] = ext(r_p[1]) + ext(r_p[3]) - ext(r_p[0]) - ext(r_p[2]);
        n_num[5] = (ext(r_p[6]) + ext(r_p[7])) <<< 1;
        n_num[6] = (ext(r_p[5]) + ext(r_p[8])) <<< 1;
        n_num[7] = (ext(r_p[6]) - ext(r_p[7])) <<< 1;
        n_num[8] = ext(r_p[2]) + ext(r_p[3]) - ext(r_p[0]) - ext(r_p[1]);
    end

    // dividend = mag * 2^15 + N, divisor = 2N; quotient is round(16384*mag/N)
    always_comb begin
        logic [qrm_pkg::S_W-1:0]  absv;
        logic [qrm_pkg::NM_W-1:0] nm;
        n_div      = '0;
        n_div.d    = {r_n, 1'b0};
        n_div.zero = (r_n == '0);
        for (int k = 0; k < qrm_pkg::LANES; k++) begin
            absv = r_num[k][qrm_pkg::S_W-1] ? qrm_pkg::S_W'(-r_num[k]) : r_num[k];
            nm   = {absv[qrm_pkg::N_W-1:0], {qrm_pkg::Q_BITS{1'b0}}}
                 + {{qrm_pkg::Q_BITS{1'b0}}, r_n};
            n_div.lane[k].neg = r_num[k][qrm_pkg::S_W-1];
            n_div.lane[k].r   = {1'b0, nm[qrm_pkg::NM_W-1:qrm_pkg::Q_BITS]};
            n_div.lane[k].low = nm[qrm_pkg::Q_BITS-1:0];
            n_div.lane[k].q   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
            r_w <= i_w;
        end
        if (en2) r_p <= n_p;
        if (en3) begin
            r_n   <= n_sum[qrm_pkg::N_W-1:0];
            r_num <= n_num;
        end
        if (en4) r_div <= n_div;
    end
endmodule

[rtl/qrm_div_stage.sv]
// ============================================================================
// qrm_div_stage: one stage of the pipelined divider
// Retires DIV_STEPS quotient bits on all nine lanes.
// ============================================================================
module qrm_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  qrm_pkg::t_div i_div,
    output logic          o_valid,
    input  logic          i_ready,
    output qrm_pkg::t_div o_div
);
    logic          r_v;
    qrm_pkg::t_div r_div, n_div;
    logic          en;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_div   = r_div;

    always_comb begin
        n_div = i_div;
        for (int k = 0; k < qrm_pkg::LANES; k++) begin
            for (int s = 0; s < qrm_pkg::DIV_STEPS; s++) begin
                n_div.lane[k] = qrm_pkg::div_step(n_div.lane[k], i_div.d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_div <= n_div;
    end
endmodule

[rtl/qrm_back.sv]
// ============================================================================
// qrm_back: output register
// Clamps, applies sign, substitutes identity for a zero quaternion.
// ============================================================================
module qrm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qrm_pkg::t_div  i_div,
    output logic           o_valid,
    input  logic           i_ready,
    output qrm_pkg::t_elem o_elem [qrm_pkg::LANES],
    output logic           o_zero
);
    logic           r_v;
    qrm_pkg::t_elem r_elem [qrm_pkg::LANES];
    qrm_pkg::t_elem n_elem [qrm_pkg::LANES];
    logic           r_zero;
    logic           en;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_elem  = r_elem;
    assign o_zero  = r_zero;

    always_comb begin
        logic [qrm_pkg::OUT_W-1:0] mag;
        for (int k = 0; k < qrm_pkg::LANES; k++) begin
            mag = {1'b0, i_div.lane[k].q};
            if (mag > qrm_pkg::OUT_W'(qrm_pkg::ONE_Q14)) mag = qrm_pkg::OUT_W'(qrm_pkg::ONE_Q14);
            if (i_div.zero) begin
                // identity: diagonal lanes are 0, 4 and 8
                n_elem[k] = (k % 4 == 0) ? qrm_pkg::OUT_W'(qrm_pkg::ONE_Q14) : '0;
            end else begin
                n_elem[k] = i_div.lane[k].neg ? qrm_pkg::t_elem'(-mag) : qrm_pkg::t_elem'(mag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_elem <= n_elem;
            r_zero <= i_div.zero;
        end
    end
endmodule

[rtl/quaternion_to_rotation_matrix.sv]
// ============================================================================
// quaternion_to_rotation_matrix: normalized quaternion to 3x3 rotation matrix
// Q3.12 quaternion in, nine Q1.14 elements (transposed layout) out.
// ============================================================================
// Fully pipelined: one transaction per cycle while the output is not stalled, through 10
// register stages (4 front stages for products, sums and dividend setup, 5 divider stages
// retiring 3 quotient bits each, 1 output register).
// Each element is round(16384 * num / N) with N = xx+yy+zz+ww, ties away from
// zero; an all-zero quaternion gives the identity with zero_norm set. Ready
// propagates per stage, so bubbles are squeezed out while the output stalls.
module quaternion_to_rotation_matrix (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qrm_quat_if.sink   i_quat,
    qrm_mat_if.source  o_mat
);
    localparam int NS = qrm_pkg::DIV_STAGES;

    logic           v [NS+1];
    logic           rdy [NS+1];
    qrm_pkg::t_div  d [NS+1];
    qrm_pkg::t_elem elem [qrm_pkg::LANES];
    logic           zero;

    qrm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_quat.valid),
        .o_ready (i_quat.ready),
        .i_x     (i_quat.quat_x),
        .i_y     (i_quat.quat_y),
        .i_z     (i_quat.quat_z),
        .i_w     (i_quat.quat_w),
        .o_valid (v[0]),
        .i_ready (rdy[0]),
        .o_div   (d[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_div
        qrm_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[g]),
            .o_ready (rdy[g]),
            .i_div   (d[g]),
            .o_valid (v[g+1]),
            .i_ready (rdy[g+1]),
            .o_div   (d[g+1])
        );
    end

    qrm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[NS]),
        .o_ready (rdy[NS]),
        .i_div   (d[NS]),
        .o_valid (o_mat.valid),
        .i_ready (o_mat.ready),
        .o_elem  (elem),
        .o_zero  (zero)
    );

    assign o_mat.elem_0    = elem[0];
    assign o_mat.elem_1    = elem[1];
    assign o_mat.elem_2    = elem[2];
    assign o_mat.elem_4    = elem[3];
    assign o_mat.elem_5    = elem[4];
    assign o_mat.elem_6    = elem[5];
    assign o_mat.elem_8    = elem[6];
    assign o_mat.elem_9    = elem[7];
    assign o_mat.elem_10   = elem[8];
    assign o_mat.zero_norm = zero;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_mat.valid)
        else $error("output valid right after reset");

    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mat.valid && o_mat.zero_norm |->
            o_mat.elem_0 == 16'sd16384 && o_mat.elem_5 == 16'sd16384 &&
            o_mat.elem_10 == 16'sd16384 && o_mat.elem_1 == 16'sd0 &&
            o_mat.elem_9 == 16'sd0)
        else $error("zero quaternion did not give identity");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mat.valid |->
            o_mat.elem_0 <= 16'sd16384 && o_mat.elem_0 >= -16'sd16384 &&
            o_mat.elem_1 <= 16'sd16384 && o_mat.elem_1 >= -16'sd16384)
        else $error("element outside plus or minus one");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[NS] && !d[NS].zero |-> d[NS].lane[0].r < d[NS].d)
        else $error("divider remainder not below divisor");
endmodule
